@@ src/char_lcd_nibble_writer_assert.svh @@
// ----------------------------------------------------------------------------
// char_lcd_nibble_writer_assert.svh
// Assertion macros for the LCD nibble writer checker.
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_NIBBLE_WRITER_ASSERT_SVH
`define CHAR_LCD_NIBBLE_WRITER_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define CLNW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CLNW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/clnw_pkg.sv @@
// ----------------------------------------------------------------------------
// clnw_pkg
// Types, codes and constants of the character LCD nibble writer.
// ----------------------------------------------------------------------------
package clnw_pkg;

  localparam int NUM_CFG     = 5;
  localparam int CFG_IDX_W   = 3;
  localparam int QUEUE_DEPTH = 2;

  // request modes
  localparam logic [2:0] MODE_INIT   = 3'd0;
  localparam logic [2:0] MODE_CMD    = 3'd1;
  localparam logic [2:0] MODE_CHAR   = 3'd2;
  localparam logic [2:0] MODE_NUM    = 3'd3;
  localparam logic [2:0] MODE_CURSOR = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FUNCTION_SET = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_OFF  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLEAR        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_MODE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_ON   = 3'd4;

  localparam logic [NUM_CFG-1:0][7:0] CFG_RESET = {8'h0C, 8'h06, 8'h01, 8'h08, 8'h28};

  localparam logic [15:0] NUM_LIMIT   = 16'd10000;
  localparam logic [12:0] RECIP_TEN   = 13'd6554;  // ceil(2^16 / 10)
  localparam logic [2:0]  CONV_STEPS  = 3'd4;
  localparam logic [3:0]  INIT_NIBS   = 4'd14;
  localparam logic [3:0]  WAKE_NIBS   = 4'd4;
  localparam logic [3:0]  BYTE_NIBS   = 4'd2;
  localparam logic [3:0]  ASCII_DIGIT = 4'h3;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] data;
    logic        row;
    logic [5:0]  column;
  } in_t;

  typedef struct packed {
    logic       reg_select;
    logic       read_write;
    logic [3:0] nibble;
    logic [5:0] pre_wait_ms;
    logic       last;
  } out_t;

  typedef enum logic [1:0] {
    JOB_INIT,
    JOB_BYTE,
    JOB_DIGITS
  } job_kind_t;

  // one classified request, as handed from front to back
  typedef struct packed {
    job_kind_t   kind;
    logic        rs;
    logic [3:0]  cnt;    // nibbles to send
    logic [15:0] data;   // byte in [7:0], or digits left-aligned
  } job_t;

  // wake-up sequence: nibble and pre-wait
  function automatic logic [3:0] wake_nibble(input logic [1:0] i);
    return (i == 2'd3) ? 4'h2 : 4'h3;
  endfunction

  function automatic logic [5:0] wake_wait(input logic [1:0] i);
    logic [5:0] w;
    case (i)
      2'd0:    w = 6'd50;
      2'd1:    w = 6'd10;
      2'd2:    w = 6'd1;
      default: w = 6'd0;
    endcase
    return w;
  endfunction

endpackage

@@ src/char_lcd_nibble_writer.sv @@
// ----------------------------------------------------------------------------
// char_lcd_nibble_writer
// Request to nibble-strobe converter for a 4-bit character LCD bus.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive in_data and raise start; the beat is taken on an edge where
//   start is high and busy is low. Modes: init, command byte, character byte,
//   decimal number, set cursor. Modes 5..7 and numbers of 10000 or more make
//   no output.
//   Output: each nibble is on out_data for one cycle with out_valid high;
//   last marks the final nibble of a request. The receiver cannot stall,
//   so nibbles leave back to back, one per cycle.
//   Config: cfg_index/cfg_wdata written when cfg_valid is high (cfg_ready is
//   always high); write only while no request is in flight.
// Flow: the front registers a request; a number stays there through the
//   divide-by-ten loop, and no new request is taken meanwhile. The job
//   then goes through the queue into the back end's job register, and each
//   nibble through the output register. Nibbles go out one per cycle: two
//   per byte request, 14 per init and two per digit. The job queue lets
//   the front take new requests while the back is still playing out.
// Reset: clears the queue and pipeline and loads the default command bytes.
// ----------------------------------------------------------------------------
module char_lcd_nibble_writer
  import clnw_pkg::*;
#(
  parameter int Q_DEPTH = QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_t                  in_data,
  output logic                 out_valid,
  output out_t                 out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_wdata
);

  logic [NUM_CFG-1:0][7:0] cfg_regs_r;
  logic q_push, q_full, q_pop, q_head_valid;
  job_t q_push_job, q_head_job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_regs_r <= CFG_RESET;
    end else if (cfg_valid && cfg_ready && cfg_index <= REG_DISPLAY_ON) begin
      cfg_regs_r[cfg_index] <= cfg_wdata;
    end
  end

  clnw_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_data (in_data),
    .q_push  (q_push),
    .q_job   (q_push_job),
    .q_full  (q_full)
  );

  clnw_queue #(.Q_DEPTH(Q_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (q_push_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_job   (q_head_job),
    .head_valid (q_head_valid)
  );

  clnw_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_regs   (cfg_regs_r),
    .head_job   (q_head_job),
    .head_valid (q_head_valid),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_data   (out_data)
  );

endmodule

@@ src/clnw_front.sv @@
// ----------------------------------------------------------------------------
// clnw_front
// Takes requests, classifies them, converts numbers to decimal digits and
// pushes one job per request that is not dropped into the queue.
// ----------------------------------------------------------------------------
module clnw_front
  import clnw_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_data,
  output logic q_push,
  output job_t q_job,
  input  logic q_full
);

  logic        fr_valid_r, fr_valid_nxt;
  in_t         fr_item_r;
  logic [2:0]  conv_cnt_r;
  logic [13:0] conv_v_r;
  logic [15:0] digits_r;
  logic [2:0]  ndig_r;

  logic        accept;
  logic        is_num, num_ok, drop, conv_done, can_push, front_done;
  logic [26:0] prod;
  logic [9:0]  quot;
  logic [13:0] quot10;
  logic [13:0] diff;
  logic [2:0]  ndig_in;
  logic [4:0]  align_sh;

  assign is_num    = (fr_item_r.mode == MODE_NUM);
  assign num_ok    = (fr_item_r.data < NUM_LIMIT);
  assign drop      = (fr_item_r.mode > MODE_CURSOR) || (is_num && !num_ok);
  assign conv_done = (conv_cnt_r == CONV_STEPS);
  assign can_push  = !drop && (!is_num || conv_done);
  assign q_push    = fr_valid_r && can_push && !q_full;
  assign front_done = fr_valid_r && (drop || q_push);
  assign busy      = fr_valid_r && !front_done;
  assign accept    = start && !busy;

  // divide by ten through the reciprocal; exact below 10000
  assign prod   = conv_v_r * RECIP_TEN;
  assign quot   = prod[25:16];
  assign quot10 = {1'b0, quot, 3'b000} + {3'b000, quot, 1'b0};
  assign diff   = conv_v_r - quot10;

  always_comb begin
    if (in_data.data >= 16'd1000)     ndig_in = 3'd4;
    else if (in_data.data >= 16'd100) ndig_in = 3'd3;
    else if (in_data.data >= 16'd10)  ndig_in = 3'd2;
    else                              ndig_in = 3'd1;
  end

  assign align_sh = {CONV_STEPS - ndig_r, 2'b00};

  always_comb begin
    q_job = '0;
    unique case (fr_item_r.mode)
      MODE_INIT: begin
        q_job.kind = JOB_INIT;
        q_job.rs   = 1'b0;
        q_job.cnt  = INIT_NIBS;
      end
      MODE_CMD: begin
        q_job.kind = JOB_BYTE;
        q_job.rs   = 1'b0;
        q_job.cnt  = BYTE_NIBS;
        q_job.data = {8'h00, fr_item_r.data[7:0]};
      end
      MODE_CHAR: begin
        q_job.kind = JOB_BYTE;
        q_job.rs   = 1'b1;
        q_job.cnt  = BYTE_NIBS;
        q_job.data = {8'h00, fr_item_r.data[7:0]};
      end
      MODE_NUM: begin
        q_job.kind = JOB_DIGITS;
        q_job.rs   = 1'b1;
        q_job.cnt  = {ndig_r, 1'b0};
        q_job.data = digits_r << align_sh;
      end
      MODE_CURSOR: begin
        q_job.kind = JOB_BYTE;
        q_job.rs   = 1'b0;
        q_job.cnt  = BYTE_NIBS;
        q_job.data = {8'h00, 1'b1, fr_item_r.row, fr_item_r.column};
      end
      default: q_job = '0;
    endcase
  end

  always_comb begin
    fr_valid_nxt = fr_valid_r;
    if (accept)          fr_valid_nxt = 1'b1;
    else if (front_done) fr_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
      conv_cnt_r <= '0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
      if (accept) begin
        conv_cnt_r <= '0;
      end else if (fr_valid_r && is_num && num_ok && !conv_done) begin
        conv_cnt_r <= conv_cnt_r + 3'd1;
      end
    end
  end

  // payload: units digit lands on top first, shifted down each step
  always_ff @(posedge clk) begin
    if (accept) begin
      fr_item_r <= in_data;
      conv_v_r  <= in_data.data[13:0];
      ndig_r    <= ndig_in;
    end else if (fr_valid_r && is_num && num_ok && !conv_done) begin
      conv_v_r <= {4'b0000, quot};
      digits_r <= {diff[3:0], digits_r[15:4]};
    end
  end

endmodule

@@ src/clnw_queue.sv @@
// ----------------------------------------------------------------------------
// clnw_queue
// Small FIFO of classified jobs between front and back.
// ----------------------------------------------------------------------------
module clnw_queue
  import clnw_pkg::*;
#(
  parameter int Q_DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t head_job,
  output logic head_valid
);

  localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

  job_t          mem [Q_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [PW:0]   count_r, count_nxt;
  logic          do_push, do_pop;

  assign full       = (count_r == (PW+1)'(Q_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = mem[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop)      count_nxt = count_r + 1'b1;
    else if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(Q_DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(Q_DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= push_job;
  end

endmodule

@@ src/clnw_back.sv @@
// ----------------------------------------------------------------------------
// clnw_back
// Plays one job out as nibble strobes, one per cycle, through an output
// register.
// ----------------------------------------------------------------------------
module clnw_back
  import clnw_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [NUM_CFG-1:0][7:0]   cfg_regs,
  input  job_t                      head_job,
  input  logic                      head_valid,
  output logic                      pop,
  output logic                      out_valid,
  output out_t                      out_data
);

  logic       bk_valid_r;
  job_t       bk_job_r;
  logic [3:0] bk_idx_r;
  logic       out_valid_r;
  out_t       out_data_r;

  logic       bk_fin;
  logic [3:0] init_j;
  logic [7:0] cur_byte;
  logic [3:0] digit;
  out_t       nib;

  assign bk_fin = bk_valid_r && (bk_idx_r == bk_job_r.cnt - 4'd1);
  assign pop    = head_valid && (!bk_valid_r || bk_fin);
  assign init_j = bk_idx_r - WAKE_NIBS;

  always_comb begin
    case (bk_idx_r[2:1])
      2'd0:    digit = bk_job_r.data[15:12];
      2'd1:    digit = bk_job_r.data[11:8];
      2'd2:    digit = bk_job_r.data[7:4];
      default: digit = bk_job_r.data[3:0];
    endcase
  end

  always_comb begin
    cur_byte = '0;
    unique case (bk_job_r.kind)
      JOB_INIT:   cur_byte = cfg_regs[init_j[3:1]];
      JOB_BYTE:   cur_byte = bk_job_r.data[7:0];
      JOB_DIGITS: cur_byte = {ASCII_DIGIT, digit};
      default:    cur_byte = '0;
    endcase
  end

  always_comb begin
    nib             = '0;
    nib.reg_select  = bk_job_r.rs;
    nib.read_write  = 1'b0;
    nib.last        = bk_fin;
    if (bk_job_r.kind == JOB_INIT && bk_idx_r < WAKE_NIBS) begin
      nib.nibble      = wake_nibble(bk_idx_r[1:0]);
      nib.pre_wait_ms = wake_wait(bk_idx_r[1:0]);
    end else begin
      // high nibble on even steps; init bytes start after the wake-up nibbles
      nib.nibble = bk_idx_r[0] ? cur_byte[3:0] : cur_byte[7:4];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bk_valid_r  <= 1'b0;
      bk_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= bk_valid_r;
      if (pop) begin
        bk_valid_r <= 1'b1;
        bk_idx_r   <= '0;
      end else if (bk_fin) begin
        bk_valid_r <= 1'b0;
      end else if (bk_valid_r) begin
        bk_idx_r <= bk_idx_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) bk_job_r <= head_job;
    out_data_r <= nib;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ src/clnw_checker.sv @@
// ----------------------------------------------------------------------------
// clnw_checker
// Port-level checks on the nibble stream of the LCD nibble writer.
// ----------------------------------------------------------------------------
`include "char_lcd_nibble_writer_assert.svh"

module clnw_checker
  import clnw_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input out_t out_data
);

  `CLNW_ASSERT_NOW(a_write_only, out_valid, out_data.read_write == 1'b0, "RW driven high")

  `CLNW_ASSERT_NOW(a_wait_code, out_valid && out_data.pre_wait_ms != 6'd0, out_data.pre_wait_ms == 6'd50 || out_data.pre_wait_ms == 6'd10 || out_data.pre_wait_ms == 6'd1, "bad pre-wait")

  // a request's nibbles leave without gaps
  `CLNW_ASSERT_NEXT(a_no_gap, out_valid && !out_data.last, out_valid, "gap inside a request")

  `CLNW_ASSERT_NEXT(a_wake_order, out_valid && out_data.pre_wait_ms == 6'd50, out_valid && out_data.pre_wait_ms == 6'd10 && out_data.nibble == 4'h3, "wake-up order broken")

  `CLNW_ASSERT_NEXT(a_switch_4bit, out_valid && out_data.pre_wait_ms == 6'd1, out_valid && out_data.nibble == 4'h2 && out_data.pre_wait_ms == 6'd0, "4-bit switch missing")

endmodule

bind char_lcd_nibble_writer clnw_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_data  (out_data)
);
